/* design/prsp_pkg.sv */
// Package for the probe request SSID parser: types, codes and constants.
`default_nettype none
package prsp_pkg;

   localparam int SSID_MAX_BYTES_DEF = 32;
   localparam logic [15:0] RT_HDR_BYTES = 16'd8;
   localparam logic [15:0] WLAN_HDR_LAST = 16'd23;
   localparam logic [7:0] SUBST_CHAR = 8'h3F;

   typedef enum logic [2:0] {
      PH_RADIOTAP  = 3'd0,
      PH_HEADER    = 3'd1,
      PH_ELEM_ID   = 3'd2,
      PH_ELEM_LEN  = 3'd3,
      PH_ELEM_DATA = 3'd4,
      PH_NOT_PROBE = 3'd5,
      PH_DROP      = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TRUNC     = 3'd1,
      ST_SHORT_RT  = 3'd2,
      ST_SHORT_HDR = 3'd3,
      ST_NOT_PROBE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_RUN   = 2'd0,
      S_FETCH = 2'd1,
      S_CHAR  = 2'd2,
      S_SUM   = 2'd3
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       capture_truncated;
   } req_type;

   typedef struct packed {
      logic [7:0]  ssid_char;
      logic        last_of_run;
      status_type  status;
      logic [1:0]  frame_type;
      logic [3:0]  frame_subtype;
      logic [11:0] seq_number;
      logic [3:0]  frag_number;
      logic        ssid_invalid;
      logic [5:0]  ssid_length;
      logic [47:0] receiver_address;
      logic [47:0] transmitter_address;
      logic [47:0] bss_address;
   } rsp_type;

   typedef struct packed {
      logic consume;
      logic rd_en;
      logic load_char;
      logic load_sum;
   } cmd_type;

   typedef struct packed {
      logic in_last;
      logic emit_more;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

/* design/prsp_ctrl.sv */
// Controller state machine for the probe request SSID parser.
`default_nettype none
module prsp_ctrl
   import prsp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_RUN: begin
            req_ready   = 1'b1;
            cmd.consume = req_valid;
            if (req_valid && stat.in_last) state_in = S_FETCH;
         end
         S_FETCH: begin
            if (stat.emit_more) begin
               cmd.rd_en = 1'b1;
               state_in  = S_CHAR;
            end else begin
               state_in = S_SUM;
            end
         end
         S_CHAR: begin
            if (stat.out_free) begin
               cmd.load_char = 1'b1;
               state_in      = S_FETCH;
            end
         end
         S_SUM: begin
            if (stat.out_free) begin
               cmd.load_sum = 1'b1;
               state_in     = S_RUN;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

endmodule
`default_nettype wire

/* design/prsp_dpath.sv */
// Datapath for the probe request SSID parser: parse state, SSID memory, output register.
`default_nettype none
module prsp_dpath
   import prsp_pkg::*;
#(
   parameter int SSID_MAX_BYTES = SSID_MAX_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   input  wire logic    rsp_ready,
   output stat_type     stat,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int IW = (SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1;
   localparam int LW = $clog2(SSID_MAX_BYTES + 1);
   localparam int AW = IW + 1;
   localparam int DEPTH = 2 ** AW;
   localparam logic [8:0] MAX9 = 9'(SSID_MAX_BYTES);

   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] rtlen_ff, rtlen_in;
   logic [7:0]  fc_ff, fc_in;
   logic [15:0] seq_ff, seq_in;
   logic [47:0] addr_ff [3];
   logic [47:0] addr_in [3];
   logic [7:0]  eid_ff, eid_in;
   logic [7:0]  eleft_ff, eleft_in;
   logic [7:0]  elen_ff, elen_in;
   logic [LW-1:0] slen_ff, slen_in;
   logic [LW-1:0] clen_ff, clen_in;
   logic [LW-1:0] idx_ff;
   logic        inv_ff, inv_in;
   logic        trunc_ff, trunc_in;
   logic        bank_ff, bank_in;
   logic        wr_en;
   logic [7:0]  wr_data;
   logic [7:0]  mem [DEPTH];
   logic [7:0]  rd_data_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;
   status_type  sum_status;
   logic [15:0] pos_bump;
   logic [7:0]  b;
   logic [7:0]  clen_ext;

   assign b        = req_data.data_byte;
   assign pos_bump = (pos_ff != 16'hFFFF) ? pos_ff + 16'd1 : pos_ff;
   assign wr_data  = (b >= 8'h20 && b <= 8'h7E) ? b : SUBST_CHAR;
   assign clen_ext = 8'(clen_ff);

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      rtlen_in = rtlen_ff;
      fc_in    = fc_ff;
      seq_in   = seq_ff;
      addr_in  = addr_ff;
      eid_in   = eid_ff;
      eleft_in = eleft_ff;
      elen_in  = elen_ff;
      slen_in  = slen_ff;
      clen_in  = clen_ff;
      inv_in   = inv_ff;
      trunc_in = trunc_ff;
      bank_in  = bank_ff;
      wr_en    = 1'b0;
      if (cmd.consume) begin
         case (phase_ff)
            PH_RADIOTAP: begin
               if (pos_ff == 16'd0 && req_data.capture_truncated) begin
                  trunc_in = 1'b1;
                  phase_in = PH_DROP;
               end else if (pos_ff == 16'd3 && {b, rtlen_ff[7:0]} < RT_HDR_BYTES) begin
                  rtlen_in = {b, rtlen_ff[7:0]};
                  phase_in = PH_DROP;
               end else begin
                  if (pos_ff == 16'd2) rtlen_in = {8'd0, b};
                  if (pos_ff == 16'd3) rtlen_in = {b, rtlen_ff[7:0]};
                  if (pos_ff >= RT_HDR_BYTES - 16'd1
                      && {1'b0, pos_ff} + 17'd1 == {1'b0, rtlen_ff}) begin
                     phase_in = PH_HEADER;
                     pos_in   = 16'd0;
                  end else begin
                     pos_in = pos_bump;
                  end
               end
            end
            PH_HEADER: begin
               if (pos_ff == 16'd0) fc_in = b;
               if (pos_ff >= 16'd4 && pos_ff <= 16'd9) addr_in[0] = {addr_ff[0][39:0], b};
               if (pos_ff >= 16'd10 && pos_ff <= 16'd15) addr_in[1] = {addr_ff[1][39:0], b};
               if (pos_ff >= 16'd16 && pos_ff <= 16'd21) addr_in[2] = {addr_ff[2][39:0], b};
               if (pos_ff == 16'd22) seq_in = {8'd0, b};
               if (pos_ff == WLAN_HDR_LAST) begin
                  seq_in   = {b, seq_ff[7:0]};
                  phase_in = ((fc_ff & 8'hFC) == 8'h40) ? PH_ELEM_ID : PH_NOT_PROBE;
               end else begin
                  pos_in = pos_bump;
               end
            end
            PH_ELEM_ID: begin
               eid_in   = b;
               phase_in = PH_ELEM_LEN;
            end
            PH_ELEM_LEN: begin
               elen_in  = b;
               eleft_in = b;
               slen_in  = '0;
               if (b == 8'd0) begin
                  if (eid_ff == 8'd0) inv_in = 1'b1;
                  phase_in = PH_ELEM_ID;
               end else begin
                  phase_in = PH_ELEM_DATA;
               end
            end
            PH_ELEM_DATA: begin
               if (eid_ff == 8'd0 && {1'b0, 8'(slen_ff)} < MAX9) begin
                  wr_en   = 1'b1;
                  slen_in = slen_ff + LW'(1);
               end
               eleft_in = eleft_ff - 8'd1;
               if (eleft_ff == 8'd1) begin
                  phase_in = PH_ELEM_ID;
                  if (eid_ff == 8'd0) begin
                     if ({1'b0, elen_ff} <= MAX9) begin
                        clen_in = LW'(elen_ff);
                        bank_in = ~bank_ff;
                     end else begin
                        inv_in = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (cmd.load_sum) begin
         phase_in = PH_RADIOTAP;
         pos_in   = '0;
         rtlen_in = '0;
         fc_in    = '0;
         seq_in   = '0;
         addr_in  = '{default: '0};
         eid_in   = '0;
         eleft_in = '0;
         elen_in  = '0;
         slen_in  = '0;
         clen_in  = '0;
         inv_in   = 1'b0;
         trunc_in = 1'b0;
      end
   end

   always_comb begin
      case (phase_ff)
         PH_RADIOTAP:  sum_status = ST_SHORT_RT;
         PH_HEADER:    sum_status = ST_SHORT_HDR;
         PH_NOT_PROBE: sum_status = ST_NOT_PROBE;
         PH_DROP:      sum_status = trunc_ff ? ST_TRUNC : ST_SHORT_RT;
         default:      sum_status = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RADIOTAP;
         pos_ff   <= '0;
         rtlen_ff <= '0;
         eid_ff   <= '0;
         eleft_ff <= '0;
         elen_ff  <= '0;
         slen_ff  <= '0;
         clen_ff  <= '0;
         inv_ff   <= 1'b0;
         trunc_ff <= 1'b0;
         bank_ff  <= 1'b0;
         idx_ff   <= '0;
         fc_ff    <= '0;
         seq_ff   <= '0;
         addr_ff  <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         rtlen_ff <= rtlen_in;
         eid_ff   <= eid_in;
         eleft_ff <= eleft_in;
         elen_ff  <= elen_in;
         slen_ff  <= slen_in;
         clen_ff  <= clen_in;
         inv_ff   <= inv_in;
         trunc_ff <= trunc_in;
         bank_ff  <= bank_in;
         fc_ff    <= fc_in;
         seq_ff   <= seq_in;
         addr_ff  <= addr_in;
         if (cmd.load_sum) idx_ff <= '0;
         else if (cmd.load_char) idx_ff <= idx_ff + LW'(1);
         if (cmd.load_char || cmd.load_sum) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // SSID memory: two banks, the committed one selected by bank_ff
   always_ff @(posedge clock) begin
      if (wr_en) mem[{~bank_ff, slen_ff[IW-1:0]}] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= mem[{bank_ff, idx_ff[IW-1:0]}];
   end

   always_comb begin
      rsp_data_in = '0;
      if (cmd.load_char) begin
         rsp_data_in.ssid_char = rd_data_ff;
      end else begin
         rsp_data_in.last_of_run = 1'b1;
         rsp_data_in.status      = sum_status;
         if (sum_status == ST_OK || sum_status == ST_NOT_PROBE) begin
            rsp_data_in.frame_type    = fc_ff[3:2];
            rsp_data_in.frame_subtype = fc_ff[7:4];
            rsp_data_in.seq_number    = seq_ff[15:4];
            rsp_data_in.frag_number   = seq_ff[3:0];
         end
         if (sum_status == ST_OK) begin
            rsp_data_in.ssid_invalid        = inv_ff;
            rsp_data_in.ssid_length         = clen_ext[5:0];
            rsp_data_in.receiver_address    = addr_ff[0];
            rsp_data_in.transmitter_address = addr_ff[1];
            rsp_data_in.bss_address         = addr_ff[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char || cmd.load_sum) rsp_data_ff <= rsp_data_in;
   end

   assign stat.in_last   = req_data.last_byte;
   assign stat.emit_more = (sum_status == ST_OK) && (idx_ff < clen_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;

endmodule
`default_nettype wire

/* design/probe_request_ssid_parser.sv */
// Top level of the probe request SSID parser.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    req_type: one packet byte
//   rsp_      out         rsp_valid/rsp_ready    rsp_type: SSID char or summary
//
// Packet bytes are taken one per cycle while no end-of-packet run is in progress.
// After the last byte, each committed SSID character passes through the
// registered read of the SSID memory, then the output load, and the summary
// follows with its own output load; the block accepts no byte during that run.
// Reset is synchronous and active high; it returns the parser to the radiotap phase.
// A stalled rsp_ready holds the output register and pauses the run.
`default_nettype none
module probe_request_ssid_parser
   import prsp_pkg::*;
#(
   parameter int SSID_MAX_BYTES = SSID_MAX_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // Sequence the parse and the end-of-packet transaction run
   prsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold parse state, SSID banks and the output register
   prsp_dpath #(
      .SSID_MAX_BYTES (SSID_MAX_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_char_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |->
         rsp_data.status == ST_OK && rsp_data.ssid_length == 6'd0)
      else $error("character transaction carries summary fields");
   a_summary_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run |-> rsp_data.ssid_char == 8'd0)
      else $error("summary transaction carries a character");
   a_bad_status_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run && rsp_data.status != ST_OK |->
         rsp_data.ssid_length == 6'd0 && rsp_data.receiver_address == 48'd0)
      else $error("failed parse reports SSID data");
`endif

endmodule
`default_nettype wire
